/* design/ptd_pkg.sv */
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants, codes and controller/datapath interface types of the
// periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int ACT_W     = 2;
  localparam int STS_W     = 3;
  localparam int ID_W      = 8;
  localparam int CTX_W     = 16;
  localparam int PER_W     = 16;
  localparam int TICK_W    = 32;

  localparam int DIV_STEPS = TICK_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NOP    = 2'd3
  } act_t;

  typedef enum logic [STS_W-1:0] {
    STS_DUE       = 3'd0,
    STS_NONE_DUE  = 3'd1,
    STS_ADDED     = 3'd2,
    STS_FULL      = 3'd3,
    STS_REMOVED   = 3'd4,
    STS_NOT_FOUND = 3'd5,
    STS_REFUSED   = 3'd6
  } sts_code_t;

  typedef struct packed {
    logic      tick_inc;
    logic      idx_clear;
    logic      idx_inc;
    logic      due_clear;
    logic      record_due;
    logic      div_start;
    logic      div_sel_add;
    logic      latch_req;
    logic      add_commit;
    logic      remove_commit;
    logic      res_valid;
    logic      res_entry;
    sts_code_t res_status;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic period_zero;
    logic found;
    logic div_done;
    logic rem_zero;
    logic idx_last;
    logic due_any;
    logic cur_due;
    logic cur_last;
  } sts_t;

endpackage

/* design/periodic_task_dispatcher.sv */
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Periodic task table with phase offsets and a wrapping tick counter.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every result shows
// on the out_ ports for one cycle with out_valid high and cannot be held off;
// out_last marks the final result of a request. Remove requests and refused
// requests answer in the cycle after they are taken and leave busy low. An
// add runs the 32-step serial modulo unit once. A tick runs that unit once
// per stored task, then, if any task is due, walks the due flags at one
// entry per cycle. The enable register resets to 0; ticks are refused until
// it is set.
module periodic_task_dispatcher (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ptd_pkg::ACT_W-1:0]  in_action,
  input  logic [ptd_pkg::ID_W-1:0]   in_task_id,
  input  logic [ptd_pkg::CTX_W-1:0]  in_context_req,
  input  logic [ptd_pkg::PER_W-1:0]  in_period,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  output logic                       out_valid,
  output logic [ptd_pkg::STS_W-1:0]  out_status,
  output logic [ptd_pkg::ID_W-1:0]   out_due_task,
  output logic [ptd_pkg::CTX_W-1:0]  out_due_context,
  output logic                       out_last
);

  ptd_pkg::cmd_t cmd;
  ptd_pkg::sts_t sts;

  ptd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_action),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  ptd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_task_id      (in_task_id),
    .in_context_req  (in_context_req),
    .in_period       (in_period),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_due_task    (out_due_task),
    .out_due_context (out_due_context),
    .out_last        (out_last)
  );

endmodule

/* design/ptd_mod.sv */
// ----------------------------------------------------------------------------
// ptd_mod
// Serial restoring modulo unit: 32-bit dividend, 16-bit divisor, one quotient
// bit per cycle, remainder valid with the done pulse.
// ----------------------------------------------------------------------------
module ptd_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ptd_pkg::TICK_W-1:0]  dividend,
  input  logic [ptd_pkg::PER_W-1:0]   divisor,
  output logic                        done,
  output logic [ptd_pkg::PER_W-1:0]   rem
);

  logic [ptd_pkg::TICK_W-1:0]    dvd_r, dvd_nxt;
  logic [ptd_pkg::PER_W-1:0]     rem_r, rem_nxt;
  logic [ptd_pkg::PER_W-1:0]     dsr_r, dsr_nxt;
  logic [ptd_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [ptd_pkg::PER_W:0]       shifted;
  logic [ptd_pkg::PER_W:0]       diff;

  always_comb begin
    shifted  = {rem_r, dvd_r[ptd_pkg::TICK_W-1]};
    diff     = shifted - {1'b0, dsr_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      rem_nxt = (shifted >= {1'b0, dsr_r}) ? diff[ptd_pkg::PER_W-1:0]
                                            : shifted[ptd_pkg::PER_W-1:0];
      cnt_nxt = cnt_r + ptd_pkg::DIV_CNT_W'(1);
      if (cnt_r == ptd_pkg::DIV_CNT_W'(ptd_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* design/ptd_dp.sv */
// ----------------------------------------------------------------------------
// ptd_dp
// Datapath: compacted task table, tick counter, scan index and due flags,
// modulo unit and the registered result stage.
// ----------------------------------------------------------------------------
module ptd_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ptd_pkg::ID_W-1:0]   in_task_id,
  input  logic [ptd_pkg::CTX_W-1:0]  in_context_req,
  input  logic [ptd_pkg::PER_W-1:0]  in_period,
  input  ptd_pkg::cmd_t              cmd,
  output ptd_pkg::sts_t              sts,
  output logic                       out_valid,
  output logic [ptd_pkg::STS_W-1:0]  out_status,
  output logic [ptd_pkg::ID_W-1:0]   out_due_task,
  output logic [ptd_pkg::CTX_W-1:0]  out_due_context,
  output logic                       out_last
);

  logic [ptd_pkg::ID_W-1:0]    tid_r [ptd_pkg::MAX_TASKS];
  logic [ptd_pkg::CTX_W-1:0]   tctx_r[ptd_pkg::MAX_TASKS];
  logic [ptd_pkg::PER_W-1:0]   tper_r[ptd_pkg::MAX_TASKS];
  logic [ptd_pkg::PER_W-1:0]   toff_r[ptd_pkg::MAX_TASKS];
  logic [ptd_pkg::ID_W-1:0]    up_id [ptd_pkg::MAX_TASKS];
  logic [ptd_pkg::CTX_W-1:0]   up_ctx[ptd_pkg::MAX_TASKS];
  logic [ptd_pkg::PER_W-1:0]   up_per[ptd_pkg::MAX_TASKS];
  logic [ptd_pkg::PER_W-1:0]   up_off[ptd_pkg::MAX_TASKS];

  logic [ptd_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [ptd_pkg::TICK_W-1:0]  tick_r, tick_nxt;
  logic [ptd_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [ptd_pkg::MAX_TASKS-1:0] due_r, due_nxt;

  logic [ptd_pkg::ID_W-1:0]    req_id_r;
  logic [ptd_pkg::CTX_W-1:0]   req_ctx_r;
  logic [ptd_pkg::PER_W-1:0]   req_per_r;

  logic [ptd_pkg::MAX_TASKS-1:0] hit;
  logic [ptd_pkg::MAX_TASKS-1:0] shift_en;
  logic                          seen;
  logic                          above;

  logic [ptd_pkg::TICK_W-1:0]  div_dvd;
  logic [ptd_pkg::PER_W-1:0]   div_dsr;
  logic                        div_done;
  logic [ptd_pkg::PER_W-1:0]   div_rem;
  logic                        rem_zero;

  logic                        ov_r;
  logic [ptd_pkg::STS_W-1:0]   ost_r;
  logic [ptd_pkg::ID_W-1:0]    oid_r;
  logic [ptd_pkg::CTX_W-1:0]   octx_r;
  logic                        olast_r;

  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < ptd_pkg::MAX_TASKS; j++) begin
      hit[j]      = (ptd_pkg::CNT_W'(j) < count_r) && (tid_r[j] == in_task_id);
      seen        = seen | hit[j];
      shift_en[j] = seen;
    end
  end

  always_comb begin
    above = 1'b0;
    for (int j = 0; j < ptd_pkg::MAX_TASKS; j++) begin
      if (ptd_pkg::IDX_W'(j) > idx_r) begin
        above = above | due_r[j];
      end
    end
  end

  assign rem_zero = (div_rem == '0);

  assign div_dvd = cmd.div_sel_add ? tick_r
                                   : tick_r - {{(ptd_pkg::TICK_W-ptd_pkg::PER_W){1'b0}},
                                               toff_r[idx_r]};
  assign div_dsr = cmd.div_sel_add ? in_period : tper_r[idx_r];

  ptd_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .rem      (div_rem)
  );

  for (genvar j = 0; j < ptd_pkg::MAX_TASKS; j++) begin : g_ent
    if (j < ptd_pkg::MAX_TASKS - 1) begin : g_up
      assign up_id[j]  = tid_r[j+1];
      assign up_ctx[j] = tctx_r[j+1];
      assign up_per[j] = tper_r[j+1];
      assign up_off[j] = toff_r[j+1];
    end else begin : g_top
      assign up_id[j]  = tid_r[j];
      assign up_ctx[j] = tctx_r[j];
      assign up_per[j] = tper_r[j];
      assign up_off[j] = toff_r[j];
    end

    always_ff @(posedge clk) begin
      if (cmd.add_commit && (count_r == ptd_pkg::CNT_W'(j))) begin
        tid_r[j]  <= req_id_r;
        tctx_r[j] <= req_ctx_r;
        tper_r[j] <= req_per_r;
        toff_r[j] <= div_rem;
      end else if (cmd.remove_commit && shift_en[j]) begin
        tid_r[j]  <= up_id[j];
        tctx_r[j] <= up_ctx[j];
        tper_r[j] <= up_per[j];
        toff_r[j] <= up_off[j];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.add_commit) begin
      count_nxt = count_r + ptd_pkg::CNT_W'(1);
    end else if (cmd.remove_commit) begin
      count_nxt = count_r - ptd_pkg::CNT_W'(1);
    end
    tick_nxt = cmd.tick_inc ? tick_r + ptd_pkg::TICK_W'(1) : tick_r;
    idx_nxt  = idx_r;
    if (cmd.idx_clear) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + ptd_pkg::IDX_W'(1);
    end
    due_nxt = due_r;
    if (cmd.due_clear) begin
      due_nxt = '0;
    end else if (cmd.record_due) begin
      due_nxt[idx_r] = rem_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tick_r  <= '0;
      idx_r   <= '0;
      due_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      tick_r  <= tick_nxt;
      idx_r   <= idx_nxt;
      due_r   <= due_nxt;
      ov_r    <= cmd.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_id_r  <= in_task_id;
      req_ctx_r <= in_context_req;
      req_per_r <= in_period;
    end
    if (cmd.res_valid) begin
      ost_r <= cmd.res_status;
      if (cmd.res_entry) begin
        oid_r   <= tid_r[idx_r];
        octx_r  <= tctx_r[idx_r];
        olast_r <= ~above;
      end else begin
        oid_r   <= '0;
        octx_r  <= '0;
        olast_r <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.count_zero  = (count_r == '0);
    sts.full        = (count_r >= ptd_pkg::CNT_W'(ptd_pkg::MAX_TASKS));
    sts.period_zero = (in_period == '0);
    sts.found       = |hit;
    sts.div_done    = div_done;
    sts.rem_zero    = rem_zero;
    sts.idx_last    = (ptd_pkg::CNT_W'(idx_r) + ptd_pkg::CNT_W'(1) == count_r);
    sts.due_any     = |due_r;
    sts.cur_due     = due_r[idx_r];
    sts.cur_last    = ~above;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_due_task    = oid_r;
  assign out_due_context = octx_r;
  assign out_last        = olast_r;

endmodule

/* design/ptd_ctrl.sv */
// ----------------------------------------------------------------------------
// ptd_ctrl
// Controller: request decode, enable register and the sequencer that walks
// the task table through the modulo unit and issues the results.
// ----------------------------------------------------------------------------
module ptd_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ptd_pkg::ACT_W-1:0]  action,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  input  ptd_pkg::sts_t              sts,
  output ptd_pkg::cmd_t              cmd,
  output logic                       busy
);

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_ADD_DIV    = 5'b00010,
    S_TICK_START = 5'b00100,
    S_TICK_DIV   = 5'b01000,
    S_EMIT       = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic          enable_r, enable_nxt;
  ptd_pkg::act_t act;

  assign act = ptd_pkg::act_t'(action);

  always_comb begin
    enable_nxt = cfg_we ? cfg_wdata : enable_r;
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (act)
            ptd_pkg::ACT_TICK: begin
              if (!enable_r) begin
                cmd.res_valid  = 1'b1;
                cmd.res_status = ptd_pkg::STS_REFUSED;
              end else begin
                cmd.tick_inc = 1'b1;
                if (sts.count_zero) begin
                  cmd.res_valid  = 1'b1;
                  cmd.res_status = ptd_pkg::STS_NONE_DUE;
                end else begin
                  cmd.idx_clear = 1'b1;
                  cmd.due_clear = 1'b1;
                  state_nxt     = S_TICK_START;
                end
              end
            end
            ptd_pkg::ACT_ADD: begin
              if (sts.full) begin
                cmd.res_valid  = 1'b1;
                cmd.res_status = ptd_pkg::STS_FULL;
              end else if (sts.period_zero) begin
                cmd.res_valid  = 1'b1;
                cmd.res_status = ptd_pkg::STS_REFUSED;
              end else begin
                cmd.latch_req   = 1'b1;
                cmd.div_start   = 1'b1;
                cmd.div_sel_add = 1'b1;
                state_nxt       = S_ADD_DIV;
              end
            end
            ptd_pkg::ACT_REMOVE: begin
              cmd.res_valid = 1'b1;
              if (sts.found) begin
                cmd.remove_commit = 1'b1;
                cmd.res_status    = ptd_pkg::STS_REMOVED;
              end else begin
                cmd.res_status = ptd_pkg::STS_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD_DIV: begin
        if (sts.div_done) begin
          cmd.add_commit = 1'b1;
          cmd.res_valid  = 1'b1;
          cmd.res_status = ptd_pkg::STS_ADDED;
          state_nxt      = S_IDLE;
        end
      end
      S_TICK_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_TICK_DIV;
      end
      S_TICK_DIV: begin
        if (sts.div_done) begin
          cmd.record_due = 1'b1;
          if (!sts.idx_last) begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_TICK_START;
          end else if (sts.due_any || sts.rem_zero) begin
            cmd.idx_clear = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            cmd.res_valid  = 1'b1;
            cmd.res_status = ptd_pkg::STS_NONE_DUE;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (sts.cur_due) begin
          cmd.res_valid  = 1'b1;
          cmd.res_entry  = 1'b1;
          cmd.res_status = ptd_pkg::STS_DUE;
        end
        if (sts.cur_due && sts.cur_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      enable_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      enable_r <= enable_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_DIV) |-> !sts.full)
    else $error("add in progress on a full table");

  a_tick_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_inc |-> enable_r)
    else $error("tick counter advanced while disabled");

  a_emit_has_due: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> sts.due_any)
    else $error("result walk with no due task");

  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && sts.cur_due && sts.cur_last) |=> (state_r == S_IDLE))
    else $error("result walk did not end on the last due task");

  a_remove_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd.remove_commit)
    else $error("table shift outside idle");

endmodule
